### rtl/sgr_pkg.sv
// Shared types, codes and the palette table for the SGR color parser.
`default_nettype none

package sgr_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] ChEsc     = 8'h1B;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChFinal   = 8'h6D;
  localparam logic [7:0] ChSep     = 8'h3B;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;

  // Parser mode codes.
  localparam logic [1:0] ModeOutside = 2'd0;
  localparam logic [1:0] ModeEsc     = 2'd1;
  localparam logic [1:0] ModeBody    = 2'd2;

  // Field status codes.
  localparam logic [1:0] StStart  = 2'd0;
  localparam logic [1:0] StSign   = 2'd1;
  localparam logic [1:0] StDigits = 2'd2;
  localparam logic [1:0] StFrozen = 2'd3;

  // Field value saturation and the foreground code range.
  localparam int unsigned FieldW     = 6;
  localparam logic [FieldW-1:0] FieldMax   = 6'd63;
  localparam logic [FieldW-1:0] CodeFirstFg = 6'd30;
  localparam logic [FieldW-1:0] CodeLastFg  = 6'd37;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegDefaultRed   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDefaultGreen = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDefaultBlue  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDefaultAlpha = 3'd3;

  // Classification of each byte.
  typedef enum logic [2:0] {
    KindText       = 3'd0,
    KindEscHeld    = 3'd1,
    KindBody       = 3'd2,
    KindEnd        = 3'd3,
    KindEscText    = 3'd4,
    KindEscTextNew = 3'd5
  } sgr_kind_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } sgr_color_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_of_text;
  } sgr_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    sgr_kind_e  byte_kind;
  } sgr_out_t;

  // Parser state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        status;
    logic              negative;
    logic [FieldW-1:0] value;
    sgr_color_t        color;
  } sgr_state_t;

  localparam sgr_color_t ResetColor = '{red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd255};

  // Eight fixed foreground colors, codes 30 to 37.
  function automatic sgr_color_t palette(input logic [2:0] idx);
    sgr_color_t c;
    c.alpha = 8'd255;
    case (idx)
      3'd0: begin c.red = 8'd0;   c.green = 8'd0;   c.blue = 8'd0;   end
      3'd1: begin c.red = 8'd196; c.green = 8'd0;   c.blue = 8'd0;   end
      3'd2: begin c.red = 8'd0;   c.green = 8'd196; c.blue = 8'd0;   end
      3'd3: begin c.red = 8'd192; c.green = 8'd126; c.blue = 8'd0;   end
      3'd4: begin c.red = 8'd0;   c.green = 8'd0;   c.blue = 8'd196; end
      3'd5: begin c.red = 8'd196; c.green = 8'd0;   c.blue = 8'd196; end
      3'd6: begin c.red = 8'd0;   c.green = 8'd196; c.blue = 8'd196; end
      default: begin c.red = 8'd196; c.green = 8'd196; c.blue = 8'd196; end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/ansi_sgr_color_parser_unit.sv
// Top level of the SGR color parser: input register, parser state, result register.
`default_nettype none

// The parser takes one text byte per clock cycle while the input is not stalled, and
// returns one result per byte: the current foreground color after that byte and a
// classification of the byte. A byte is registered on transfer, goes through the
// parser's next-state logic, and its result is registered in the result register,
// from which it is offered. A new byte can be taken while the last is in flight,
// and the parser state (mode, open field and current color) is updated once per byte.
// The default color restored by code zero comes from four 8-bit registers written
// through the configuration port (index 0 red, 1 green, 2 blue, 3 alpha; other
// indexes are ignored); they should be written only while no byte is in flight.

module ansi_sgr_color_parser_unit (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  sgr_pkg::sgr_in_t             in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output sgr_pkg::sgr_out_t            out_data_o,
  input  wire                          cfg_we_i,
  input  wire [sgr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [7:0]                    cfg_data_i
);

  logic                in_valid_q;
  sgr_pkg::sgr_in_t    in_q;
  logic                out_valid_q;
  sgr_pkg::sgr_out_t   out_q;
  sgr_pkg::sgr_out_t   out_d;
  sgr_pkg::sgr_state_t state_q;
  sgr_pkg::sgr_state_t state_d;
  sgr_pkg::sgr_color_t dflt_q;
  logic                adv;
  logic                fire;
  logic                in_xfer;

  // The parse stage moves forward whenever the result register is free or drains.
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Default color registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd255};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sgr_pkg::RegDefaultRed:   dflt_q.red   <= cfg_data_i;
        sgr_pkg::RegDefaultGreen: dflt_q.green <= cfg_data_i;
        sgr_pkg::RegDefaultBlue:  dflt_q.blue  <= cfg_data_i;
        sgr_pkg::RegDefaultAlpha: dflt_q.alpha <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
  end

  sgr_step u_step (
    .state_i (state_q),
    .in_i    (in_q),
    .dflt_i  (dflt_q),
    .state_o (state_d),
    .out_o   (out_d)
  );

  // Parser state advances once per byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= sgr_pkg::ModeOutside;
      state_q.status   <= sgr_pkg::StStart;
      state_q.negative <= 1'b0;
      state_q.value    <= '0;
      state_q.color    <= sgr_pkg::ResetColor;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### rtl/sgr_step.sv
// Next-state logic of the parser: consumes one byte and classifies it.
`default_nettype none

module sgr_step (
  input  sgr_pkg::sgr_state_t state_i,
  input  sgr_pkg::sgr_in_t    in_i,
  input  sgr_pkg::sgr_color_t dflt_i,
  output sgr_pkg::sgr_state_t state_o,
  output sgr_pkg::sgr_out_t   out_o
);

  logic [7:0]             c;
  logic                   last;
  logic                   is_digit;
  logic [9:0]             accum;
  logic [sgr_pkg::FieldW-1:0] code_off;
  sgr_pkg::sgr_color_t    applied;
  sgr_pkg::sgr_kind_e     kind;
  sgr_pkg::sgr_state_t    nxt;

  assign c        = in_i.text_byte;
  assign last     = in_i.last_of_text;
  assign is_digit = c inside {[sgr_pkg::ChZero:sgr_pkg::ChNine]};

  // Decimal accumulation; the low nibble of an ASCII digit is its value.
  assign accum = {4'd0, state_i.value} * 10'd10 + {6'd0, c[3:0]};

  // Color that results when the open field is closed by ';' or 'm'.
  assign code_off = state_i.value - sgr_pkg::CodeFirstFg;
  always_comb begin
    applied = state_i.color;
    if (state_i.status == sgr_pkg::StDigits || state_i.status == sgr_pkg::StFrozen) begin
      if (state_i.negative && state_i.value != '0) begin
        applied = state_i.color;
      end else if (state_i.value == '0) begin
        applied = dflt_i;
      end else if (state_i.value >= sgr_pkg::CodeFirstFg &&
                   state_i.value <= sgr_pkg::CodeLastFg) begin
        applied = sgr_pkg::palette(code_off[2:0]);
      end
    end
  end

  // Mode handling and field parsing.
  always_comb begin
    nxt  = state_i;
    kind = sgr_pkg::KindText;
    case (state_i.mode)
      sgr_pkg::ModeEsc: begin
        if (c == sgr_pkg::ChBracket) begin
          kind         = sgr_pkg::KindBody;
          nxt.status   = sgr_pkg::StStart;
          nxt.negative = 1'b0;
          nxt.value    = '0;
          nxt.mode     = last ? sgr_pkg::ModeOutside : sgr_pkg::ModeBody;
        end else if (c == sgr_pkg::ChEsc && !last) begin
          kind     = sgr_pkg::KindEscTextNew;
          nxt.mode = sgr_pkg::ModeEsc;
        end else begin
          kind     = sgr_pkg::KindEscText;
          nxt.mode = sgr_pkg::ModeOutside;
        end
      end
      sgr_pkg::ModeBody: begin
        kind = sgr_pkg::KindBody;
        if (c == sgr_pkg::ChFinal || c == sgr_pkg::ChSep) begin
          nxt.color    = applied;
          nxt.status   = sgr_pkg::StStart;
          nxt.negative = 1'b0;
          nxt.value    = '0;
          if (c == sgr_pkg::ChFinal) begin
            kind     = sgr_pkg::KindEnd;
            nxt.mode = sgr_pkg::ModeOutside;
          end else begin
            nxt.mode = last ? sgr_pkg::ModeOutside : sgr_pkg::ModeBody;
          end
        end else begin
          if (state_i.status == sgr_pkg::StStart && c == sgr_pkg::ChMinus) begin
            nxt.status   = sgr_pkg::StSign;
            nxt.negative = 1'b1;
          end else if (state_i.status != sgr_pkg::StFrozen && is_digit) begin
            nxt.value  = (accum > {4'd0, sgr_pkg::FieldMax}) ? sgr_pkg::FieldMax
                                                             : accum[sgr_pkg::FieldW-1:0];
            nxt.status = sgr_pkg::StDigits;
          end else if (state_i.status == sgr_pkg::StDigits) begin
            nxt.status = sgr_pkg::StFrozen;
          end else if (state_i.status != sgr_pkg::StFrozen) begin
            // A field without digits freezes as a value that changes nothing.
            nxt.status   = sgr_pkg::StFrozen;
            nxt.negative = 1'b1;
            nxt.value    = sgr_pkg::FieldMax;
          end
          // End of text inside a body drops the open field.
          if (last) begin
            nxt.status   = sgr_pkg::StStart;
            nxt.negative = 1'b0;
            nxt.value    = '0;
            nxt.mode     = sgr_pkg::ModeOutside;
          end
        end
      end
      default: begin
        if (c == sgr_pkg::ChEsc && !last) begin
          kind     = sgr_pkg::KindEscHeld;
          nxt.mode = sgr_pkg::ModeEsc;
        end else begin
          kind     = sgr_pkg::KindText;
          nxt.mode = sgr_pkg::ModeOutside;
        end
      end
    endcase
  end

  assign state_o         = nxt;
  assign out_o.red       = nxt.color.red;
  assign out_o.green     = nxt.color.green;
  assign out_o.blue      = nxt.color.blue;
  assign out_o.alpha     = nxt.color.alpha;
  assign out_o.byte_kind = kind;

endmodule

`default_nettype wire

### rtl/sgr_checker.sv
// Port-level checks of the SGR color parser, bound to its top level.
`default_nettype none

module sgr_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_stall_o,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input sgr_pkg::sgr_out_t          out_data_o
);

  logic                in_xfer;
  logic                out_xfer;
  sgr_pkg::sgr_color_t last_color_q;
  sgr_pkg::sgr_color_t shown;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign shown    = '{red: out_data_o.red, green: out_data_o.green,
                      blue: out_data_o.blue, alpha: out_data_o.alpha};

  // Color of the most recent result transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_color_q <= sgr_pkg::ResetColor;
    end else if (out_xfer) begin
      last_color_q <= shown;
    end
  end

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Only sequence bytes can change the color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_data_o.byte_kind != sgr_pkg::KindBody &&
    out_data_o.byte_kind != sgr_pkg::KindEnd |-> shown == last_color_q)
    else $error("color changed on a text byte");

  // A new result is offered only after an input transfer, through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_xfer, 2))
    else $error("result without a matching input transfer");

endmodule

bind ansi_sgr_color_parser_unit sgr_checker u_sgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
